FILE: design/itoa_pkg.sv
// Shared types, constants and the digit lookup for the integer to ASCII formatter.
package itoa_pkg;

    localparam int MAX_WIDTH  = 60;
    localparam int NUM_DIGITS = 22;   // octal needs 22 digits for 64 bits
    localparam int BCD_DIGITS = 20;
    localparam int VALUE_W    = 64;

    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;
    localparam logic [1:0] SIGN_MINUS = 2'd3;

    localparam int FLAG_ZERO_PAD = 0;
    localparam int FLAG_ALT      = 1;
    localparam int FLAG_GROUP    = 2;
    localparam int FLAG_UPPER    = 3;
    localparam int FLAG_LEFT     = 4;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_COMMA   = 8'h2c;
    localparam logic [7:0] CHAR_X       = 8'h78;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_LEN,
        S_PRE0,
        S_PREX,
        S_SIGN,
        S_LPAD,
        S_DIG,
        S_COMMA,
        S_RPAD
    } t_state;

    function automatic logic [7:0] f_digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'b0, d};
        end else begin
            return base + {4'b0, d - 4'd10};
        end
    endfunction

endpackage

FILE: design/itoa_if.sv
// Valid/ready channel interfaces for number words in and character words out.
interface itoa_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  radix_select;
    logic [5:0]  field_width;
    logic [1:0]  sign_mode;
    logic [4:0]  format_flags;

    modport source (output valid, value, radix_select, field_width, sign_mode,
                    format_flags, input ready);
    modport sink   (input valid, value, radix_select, field_width, sign_mode,
                    format_flags, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_char;

    modport source (output valid, char_out, last_char, input ready);
    modport sink   (input valid, char_out, last_char, output ready);
endinterface

FILE: design/integer_to_ascii_formatter.sv
// Sequence: decimal first runs the binary-to-BCD shift steps, octal/hex skip them; then
// the leading-zero scan and the length step run before the first character.
// Characters (up to 62) then leave one per cycle through the output register while it is
// not stalled by o_out.ready. The next word is accepted once the last character is in the
// output register.
// Reset: synchronous active-low i_rst_n returns the sequencer to idle, output empty.
module integer_to_ascii_formatter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    itoa_in_if.sink         i_in,
    itoa_out_if.source      o_out
);

    itoa_pkg::t_state r_state, n_state;

    logic [itoa_pkg::NUM_DIGITS-1:0][3:0] r_dig, n_dig;
    logic [itoa_pkg::VALUE_W-1:0]         r_val, n_val;
    logic [5:0]                           r_cnt, n_cnt;
    logic [2:0]                           r_q, n_q;
    logic [1:0]                           r_m, n_m;
    logic [5:0]                           r_pad, n_pad;
    logic [1:0]                           r_radix, n_radix;
    logic [5:0]                           r_width, n_width;
    logic [1:0]                           r_smode, n_smode;
    logic [4:0]                           r_flags, n_flags;
    logic                                 r_out_valid, n_out_valid;
    logic [7:0]                           r_char, n_char;
    logic                                 r_last, n_last;

    logic       slot;
    logic       is_dec, is_oct, more, comma_next, left, accept;
    logic [5:0] len, pad_calc, pad_sel;
    logic [2:0] q_dec;
    logic [1:0] m_dec;
    itoa_pkg::t_state w_start, w_after_prefix, w_after_sign;

    logic [itoa_pkg::NUM_DIGITS-1:0][3:0] load_dig;
    logic [65:0]                          oct_ext;
    logic [itoa_pkg::BCD_DIGITS-1:0][3:0] bcd_adj;
    logic [itoa_pkg::BCD_DIGITS*4-1:0]    bcd_next;

    assign slot   = !r_out_valid || o_out.ready;
    assign accept = i_in.valid && i_in.ready;
    assign is_dec = (r_radix == itoa_pkg::RADIX_DEC);
    assign is_oct = (r_radix == itoa_pkg::RADIX_OCT);
    assign left   = r_flags[itoa_pkg::FLAG_LEFT];

    // digits still to come after the current top digit: 3*q + m
    assign more       = (r_q != 3'd0) || (r_m != 2'd0);
    assign comma_next = r_flags[itoa_pkg::FLAG_GROUP] && (r_m == 2'd0) && (r_q != 3'd0);
    assign m_dec      = (r_m == 2'd0) ? 2'd2 : r_m - 2'd1;
    assign q_dec      = (r_m == 2'd0) ? r_q - 3'd1 : r_q;

    assign len = {2'b0, r_q, 1'b0} + {3'b0, r_q} + {4'b0, r_m} + 6'd1
               + (r_flags[itoa_pkg::FLAG_GROUP] ? {3'b0, r_q} : 6'd0);
    assign pad_calc = (r_width > len) ? r_width - len : 6'd0;
    assign pad_sel  = (r_state == itoa_pkg::S_LEN) ? pad_calc : r_pad;

    assign w_after_sign   = (!left && pad_sel != 6'd0) ? itoa_pkg::S_LPAD : itoa_pkg::S_DIG;
    assign w_after_prefix = (is_dec && r_smode != itoa_pkg::SIGN_NONE) ? itoa_pkg::S_SIGN
                                                                        : w_after_sign;
    assign w_start = (r_flags[itoa_pkg::FLAG_ALT] && !is_dec) ? itoa_pkg::S_PRE0
                                                               : w_after_prefix;

    // octal and hex digits are fixed slices of the value, most significant at the top
    always_comb begin
        oct_ext  = {2'b0, i_in.value};
        load_dig = '0;
        if (i_in.radix_select == itoa_pkg::RADIX_OCT) begin
            for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
                load_dig[i] = {1'b0, oct_ext[3*i +: 3]};
            end
        end else begin
            for (int i = 0; i < 16; i++) begin
                load_dig[i+6] = i_in.value[4*i +: 4];
            end
        end
    end

    // one double-dabble step on the BCD digits held in the low slots
    always_comb begin
        for (int i = 0; i < itoa_pkg::BCD_DIGITS; i++) begin
            bcd_adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
        bcd_next = {bcd_adj[itoa_pkg::BCD_DIGITS-1][2:0], bcd_adj[itoa_pkg::BCD_DIGITS-2:0],
                    r_val[itoa_pkg::VALUE_W-1]};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itoa_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.radix_select == itoa_pkg::RADIX_DEC) ? itoa_pkg::S_CONV
                                                                         : itoa_pkg::S_SCAN;
                end
            end
            itoa_pkg::S_CONV: begin
                if (r_cnt == 6'd63) n_state = itoa_pkg::S_SCAN;
            end
            itoa_pkg::S_SCAN: begin
                if (!(r_dig[itoa_pkg::NUM_DIGITS-1] == 4'd0 && more)) n_state = itoa_pkg::S_LEN;
            end
            itoa_pkg::S_LEN: n_state = w_start;
            itoa_pkg::S_PRE0: begin
                if (slot) n_state = is_oct ? w_after_prefix : itoa_pkg::S_PREX;
            end
            itoa_pkg::S_PREX: begin
                if (slot) n_state = w_after_prefix;
            end
            itoa_pkg::S_SIGN: begin
                if (slot) n_state = w_after_sign;
            end
            itoa_pkg::S_LPAD: begin
                if (slot && r_pad == 6'd1) n_state = itoa_pkg::S_DIG;
            end
            itoa_pkg::S_DIG: begin
                if (slot) begin
                    if (comma_next)                n_state = itoa_pkg::S_COMMA;
                    else if (more)                 n_state = itoa_pkg::S_DIG;
                    else if (left && r_pad != 6'd0) n_state = itoa_pkg::S_RPAD;
                    else                           n_state = itoa_pkg::S_IDLE;
                end
            end
            itoa_pkg::S_COMMA: begin
                if (slot) n_state = itoa_pkg::S_DIG;
            end
            itoa_pkg::S_RPAD: begin
                if (slot && r_pad == 6'd1) n_state = itoa_pkg::S_IDLE;
            end
            default: n_state = itoa_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_dig   = r_dig;
        n_val   = r_val;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_m     = r_m;
        n_pad   = r_pad;
        n_radix = r_radix;
        n_width = r_width;
        n_smode = r_smode;
        n_flags = r_flags;
        case (r_state)
            itoa_pkg::S_IDLE: begin
                if (accept) begin
                    n_radix = i_in.radix_select;
                    n_width = (i_in.field_width > 6'(itoa_pkg::MAX_WIDTH))
                            ? 6'(itoa_pkg::MAX_WIDTH) : i_in.field_width;
                    n_smode = i_in.sign_mode;
                    n_flags = i_in.format_flags;
                    n_val   = i_in.value;
                    n_cnt   = 6'd0;
                    if (i_in.radix_select == itoa_pkg::RADIX_OCT) begin
                        n_dig = load_dig;
                        n_q   = 3'd7;
                        n_m   = 2'd0;
                    end else if (i_in.radix_select == itoa_pkg::RADIX_DEC) begin
                        n_dig = '0;
                        n_q   = 3'd6;
                        n_m   = 2'd1;
                    end else begin
                        n_dig = load_dig;
                        n_q   = 3'd5;
                        n_m   = 2'd0;
                    end
                end
            end
            itoa_pkg::S_CONV: begin
                n_val = {r_val[itoa_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 6'd1;
                // last step moves the BCD digits to the top slots
                if (r_cnt == 6'd63) n_dig = {bcd_next, 8'b0};
                else                n_dig = {8'b0, bcd_next};
            end
            itoa_pkg::S_SCAN: begin
                if (r_dig[itoa_pkg::NUM_DIGITS-1] == 4'd0 && more) begin
                    n_dig = {r_dig[itoa_pkg::NUM_DIGITS-2:0], 4'd0};
                    n_q   = q_dec;
                    n_m   = m_dec;
                end
            end
            itoa_pkg::S_LEN: n_pad = pad_calc;
            itoa_pkg::S_LPAD, itoa_pkg::S_RPAD: begin
                if (slot) n_pad = r_pad - 6'd1;
            end
            itoa_pkg::S_DIG: begin
                if (slot) begin
                    n_dig = {r_dig[itoa_pkg::NUM_DIGITS-2:0], 4'd0};
                    n_q   = q_dec;
                    n_m   = m_dec;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        if (slot) begin
            n_out_valid = 1'b1;
            n_last      = 1'b0;
            case (r_state)
                itoa_pkg::S_PRE0: n_char = itoa_pkg::CHAR_ZERO;
                itoa_pkg::S_PREX: n_char = itoa_pkg::CHAR_X;
                itoa_pkg::S_SIGN: begin
                    case (r_smode)
                        itoa_pkg::SIGN_PLUS:  n_char = itoa_pkg::CHAR_PLUS;
                        itoa_pkg::SIGN_SPACE: n_char = itoa_pkg::CHAR_SPACE;
                        default:              n_char = itoa_pkg::CHAR_MINUS;
                    endcase
                end
                itoa_pkg::S_LPAD: begin
                    n_char = r_flags[itoa_pkg::FLAG_ZERO_PAD] ? itoa_pkg::CHAR_ZERO
                                                              : itoa_pkg::CHAR_SPACE;
                end
                itoa_pkg::S_DIG: begin
                    n_char = itoa_pkg::f_digit_char(r_dig[itoa_pkg::NUM_DIGITS-1],
                                                    r_flags[itoa_pkg::FLAG_UPPER]);
                    n_last = !more && !(left && r_pad != 6'd0);
                end
                itoa_pkg::S_COMMA: n_char = itoa_pkg::CHAR_COMMA;
                itoa_pkg::S_RPAD: begin
                    n_char = itoa_pkg::CHAR_SPACE;
                    n_last = (r_pad == 6'd1);
                end
                default: n_out_valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itoa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dig   <= n_dig;
        r_val   <= n_val;
        r_cnt   <= n_cnt;
        r_q     <= n_q;
        r_m     <= n_m;
        r_pad   <= n_pad;
        r_radix <= n_radix;
        r_width <= n_width;
        r_smode <= n_smode;
        r_flags <= n_flags;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign i_in.ready      = (r_state == itoa_pkg::S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.char_out  = r_char;
    assign o_out.last_char = r_last;

endmodule
